// ----- rtl/knn_weighted_denoise_assert.svh -----
// Assertion macros for the denoise filter.
`ifndef KNN_WEIGHTED_DENOISE_ASSERT_SVH
`define KNN_WEIGHTED_DENOISE_ASSERT_SVH

// ante in one cycle implies cons in the next, outside reset
`define KNNWD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("knnwd: next-cycle check failed");

// cond never holds outside reset
`define KNNWD_ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("knnwd: forbidden condition seen");

// ante in one cycle implies cons in the next, reset included
`define KNNWD_ASSERT_AFTER(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("knnwd: post-reset check failed");

`endif

// ----- rtl/knnwd_pkg.sv -----
package knnwd_pkg;

  // Frame store geometry (MAX_COLS is a power of two: address is {row, col})
  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;
  localparam int MAX_RADIUS = 8;
  localparam int WEIGHT_FRAC_BITS = 16;

  localparam int ROW_W = $clog2(MAX_ROWS);
  localparam int COL_W = $clog2(MAX_COLS);
  localparam int ADDR_W = ROW_W + COL_W;
  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int CH = 3;
  localparam int PIX_W = 8 * CH;

  // Stream payload widths
  localparam int IN_FIELDS_W = ROW_W + COL_W + PIX_W;
  localparam int IN_TDATA_W = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = PIX_W;

  // Configuration port
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIUS     = 3'd0,
    REG_FRAME_ROWS = 3'd1,
    REG_FRAME_COLS = 3'd2,
    REG_INV_H_SQ   = 3'd3,
    REG_COLOR_MODE = 3'd4
  } knnwd_reg_t;

  localparam int RAD_W = $clog2(MAX_RADIUS + 1);
  localparam int DIM_W = ROW_W + 1;
  localparam logic [3:0] RADIUS_RST = 4'd2;
  localparam logic [6:0] FRAME_ROWS_RST = 7'd64;
  localparam logic [6:0] FRAME_COLS_RST = 7'd64;
  localparam logic [15:0] INV_H_SQ_RST = 16'd655;

  // Window arithmetic
  localparam int OFF_W = RAD_W + 1;          // signed offset dr, dc
  localparam int SUM_W = OFF_W + 1;          // signed dr + dc
  localparam int CRD_W = ROW_W + 2;          // signed neighbour coordinate
  localparam int S2_W = 2 * SUM_W;
  localparam int SQ_W = S2_W + 8;            // spatial dividend and quotient
  localparam int RSQ_W = 2 * RAD_W;
  localparam int SDV_W = SQ_W + RSQ_W;
  localparam int SDIV_STEPS = SQ_W;

  // Range argument
  localparam int DSQ_W = 16;
  localparam int RARG_W = DSQ_W + 16 - 8;

  // Exponential: Q0.24 product chain, one table entry per argument bit
  localparam int EXP_STEPS = 13;
  localparam int EXPK_W = $clog2(EXP_STEPS);
  localparam int EXP_W = 25;
  localparam logic [EXP_W-1:0] EXP_ONE = 25'd16777216;
  localparam int EXP_HALF = 1 << 23;
  localparam int EXP_SH = 24 - WEIGHT_FRAC_BITS;
  localparam int EXP_RND = (EXP_SH > 0) ? (1 << (EXP_SH - 1)) : 0;
  localparam int W_W = WEIGHT_FRAC_BITS + 1;
  localparam int W_HALF = 1 << (WEIGHT_FRAC_BITS - 1);

  localparam logic [23:0] EXP_TAB [EXP_STEPS] = '{
    24'd16711808, 24'd16646655, 24'd16517109, 24'd16261035, 24'd15760736,
    24'd14805841, 24'd13066109, 24'd10175896, 24'd6171993, 24'd2270549,
    24'd307285, 24'd5628, 24'd2
  };

  // Accumulators and final division
  localparam int MAXN_W = $clog2(4 * MAX_RADIUS * MAX_RADIUS);
  localparam int DEN_W = W_W + 8;
  localparam int NUM_W = W_W + 8 + MAXN_W;
  localparam int FDIV_STEPS = 8;

  localparam int STEP_W = $clog2(SDIV_STEPS);
  localparam logic [STEP_W-1:0] SDIV_LAST = STEP_W'(SDIV_STEPS - 1);
  localparam logic [STEP_W-1:0] EXP_LAST = STEP_W'(EXP_STEPS - 1);
  localparam logic [STEP_W-1:0] FDIV_LAST = STEP_W'(FDIV_STEPS - 1);

  // Controller to datapath commands
  typedef struct packed {
    logic store;
    logic latch;
    logic cread;
    logic cload;
    logic nread;
    logic nload;
    logic sq;
    logic rarg;
    logic sdiv;
    logic expo;
    logic rnd;
    logic wmul;
    logic acc;
    logic adv;
    logic finit;
    logic fdiv;
    logic oload;
    logic [STEP_W-1:0] step;
  } knnwd_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic in_frame;
    logic last_pos;
    logic rad_zero;
  } knnwd_stat_t;

  // One step of the exp chain: r * exp(-2^(k-8)), rounded back to Q0.24
  function automatic logic [EXP_W-1:0] exp_step(input logic [EXP_W-1:0] r,
                                                input logic [EXPK_W-1:0] k);
    logic [48:0] p;
    p = 49'(r) * 49'(EXP_TAB[k]) + 49'(EXP_HALF);
    return p[48:24];
  endfunction

  // Q0.24 to weight precision; arguments at or above 32.0 give zero
  function automatic logic [W_W-1:0] exp_round(input logic [EXP_W-1:0] r,
                                               input logic big);
    logic [EXP_W:0] t;
    t = (EXP_W + 1)'(r) + (EXP_W + 1)'(EXP_RND);
    return big ? '0 : t[EXP_SH +: W_W];
  endfunction

endpackage

// ----- rtl/knnwd_ram.sv -----
module knnwd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/knnwd_dp.sv -----
module knnwd_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [knnwd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [knnwd_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic [knnwd_pkg::IN_TDATA_W-1:0]    s_tdata,
  input  knnwd_pkg::knnwd_cmd_t               cmd,
  output knnwd_pkg::knnwd_stat_t              stat,
  output logic [knnwd_pkg::OUT_TDATA_W-1:0]   m_tdata
);
  import knnwd_pkg::*;

  // configuration registers
  logic [3:0]  radius;
  logic [6:0]  frame_rows;
  logic [6:0]  frame_cols;
  logic [15:0] inv_h_sq;
  logic        color_mode;

  logic [RAD_W-1:0] rad_eff;
  logic [DIM_W-1:0] rows_eff;
  logic [DIM_W-1:0] cols_eff;
  logic signed [OFF_W-1:0] rad_s;
  logic signed [OFF_W-1:0] lim;
  logic [RSQ_W-1:0] rsq;

  // input unpack
  logic [ROW_W-1:0] in_row;
  logic [COL_W-1:0] in_col;
  logic [PIX_W-1:0] in_pix;

  // item and window state
  logic [ROW_W-1:0] row_q;
  logic [COL_W-1:0] col_q;
  logic [PIX_W-1:0] centre;
  logic [PIX_W-1:0] pixel;
  logic signed [OFF_W-1:0] dr;
  logic signed [OFF_W-1:0] dc;
  logic signed [CRD_W-1:0] nr;
  logic signed [CRD_W-1:0] nc;
  logic signed [SUM_W-1:0] s_sum;
  logic [SUM_W-1:0] s_mag;

  logic [ADDR_W-1:0] raddr;
  logic [PIX_W-1:0] rdata;

  // per-neighbour pipeline registers
  logic [7:0]        diff [CH];
  logic [DSQ_W-1:0]  dsq [CH];
  logic [RARG_W-1:0] rarg [CH];
  logic [EXP_W-1:0]  er [CH];
  logic [W_W-1:0]    wr [CH];
  logic [W_W-1:0]    wt [CH];
  logic [SQ_W-1:0]   srem;
  logic [SQ_W-1:0]   squo;
  logic [EXP_W-1:0]  es;
  logic [W_W-1:0]    ws;

  // accumulators and final divide
  logic [NUM_W-1:0] num [CH];
  logic [DEN_W-1:0] den [CH];
  logic [NUM_W-1:0] frem [CH];
  logic [7:0]       fq [CH];

  logic [SDV_W-1:0]   sdv;
  logic [EXPK_W-1:0]  ek;
  logic [2:0]         fk;
  logic [2*W_W-1:0]   wprod [CH];
  logic [31:0]        rprod [CH];
  logic [7:0]         cv [CH];
  logic [7:0]         pv [CH];
  logic [NUM_W-1:0]   fdv [CH];

  assign in_row = s_tdata[ROW_W-1:0];
  assign in_col = s_tdata[ROW_W +: COL_W];
  assign in_pix = s_tdata[ROW_W + COL_W +: PIX_W];

  // config write
  always_ff @(posedge clk) begin
    if (rst) begin
      radius     <= RADIUS_RST;
      frame_rows <= FRAME_ROWS_RST;
      frame_cols <= FRAME_COLS_RST;
      inv_h_sq   <= INV_H_SQ_RST;
      color_mode <= 1'b1;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_RADIUS:     radius <= cfg_data[3:0];
        REG_FRAME_ROWS: frame_rows <= cfg_data[6:0];
        REG_FRAME_COLS: frame_cols <= cfg_data[6:0];
        REG_INV_H_SQ:   inv_h_sq <= cfg_data[15:0];
        REG_COLOR_MODE: color_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // saturated geometry
  assign rad_eff  = (radius > 4'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : RAD_W'(radius);
  assign rows_eff = (frame_rows > 7'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : DIM_W'(frame_rows);
  assign cols_eff = (frame_cols > 7'(MAX_COLS)) ? DIM_W'(MAX_COLS) : DIM_W'(frame_cols);
  assign rad_s    = $signed({1'b0, rad_eff});
  assign lim      = rad_s - OFF_W'(1);
  assign rsq      = RSQ_W'(rad_eff) * RSQ_W'(rad_eff);

  // neighbour coordinates and window status
  assign nr = CRD_W'($signed({2'b00, row_q})) + CRD_W'(dr);
  assign nc = CRD_W'($signed({2'b00, col_q})) + CRD_W'(dc);
  assign s_sum = SUM_W'(dr) + SUM_W'(dc);
  assign s_mag = s_sum[SUM_W-1] ? SUM_W'(-s_sum) : SUM_W'(s_sum);

  assign stat.in_frame = !nr[CRD_W-1] && (nr[CRD_W-2:0] < rows_eff)
                      && !nc[CRD_W-1] && (nc[CRD_W-2:0] < cols_eff);
  assign stat.last_pos = (dr == lim) && (dc == lim);
  assign stat.rad_zero = (rad_eff == '0);

  // frame store
  assign raddr = cmd.cread ? {row_q, col_q} : {nr[ROW_W-1:0], nc[COL_W-1:0]};

  knnwd_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (cmd.store),
    .waddr ({in_row, in_col}),
    .wdata (in_pix),
    .raddr (raddr),
    .rdata (rdata)
  );

  // per-channel combinational terms
  assign sdv = SDV_W'(rsq) << cmd.step;
  assign ek  = cmd.step[EXPK_W-1:0];
  assign fk  = cmd.step[2:0];

  always_comb begin
    for (int i = 0; i < CH; i++) begin
      cv[i]    = centre[8*i +: 8];
      pv[i]    = rdata[8*i +: 8];
      rprod[i] = 32'(dsq[i]) * 32'(inv_h_sq);
      wprod[i] = (2*W_W)'(ws) * (2*W_W)'(wr[i]) + (2*W_W)'(W_HALF);
      fdv[i]   = NUM_W'(den[i]) << fk;
    end
  end

  // item latch, centre, window counters
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      row_q <= in_row;
      col_q <= in_col;
    end
    if (cmd.cload) begin
      centre <= rdata;
      dr <= -rad_s;
      dc <= -rad_s;
    end else if (cmd.adv) begin
      if (dc == lim) begin
        dc <= -rad_s;
        dr <= dr + OFF_W'(1);
      end else begin
        dc <= dc + OFF_W'(1);
      end
    end
  end

  // neighbour weight pipeline
  always_ff @(posedge clk) begin
    if (cmd.nload) begin
      pixel <= rdata;
      srem  <= {S2_W'(s_mag) * S2_W'(s_mag), 8'd0};
      squo  <= '0;
      for (int i = 0; i < CH; i++) begin
        diff[i] <= (pv[i] > cv[i]) ? pv[i] - cv[i] : cv[i] - pv[i];
      end
    end
    if (cmd.sq) begin
      for (int i = 0; i < CH; i++) begin
        dsq[i] <= DSQ_W'(diff[i]) * DSQ_W'(diff[i]);
      end
    end
    if (cmd.rarg) begin
      es <= EXP_ONE;
      for (int i = 0; i < CH; i++) begin
        rarg[i] <= rprod[i][31:8];
        er[i]   <= EXP_ONE;
      end
    end
    // spatial argument: restoring divide by R^2, one quotient bit a cycle
    if (cmd.sdiv) begin
      if (SDV_W'(srem) >= sdv) begin
        srem <= SQ_W'(SDV_W'(srem) - sdv);
        squo[cmd.step] <= 1'b1;
      end
    end
    // exp chains, one argument bit a cycle
    if (cmd.expo) begin
      if (squo[ek]) begin
        es <= exp_step(es, ek);
      end
      for (int i = 0; i < CH; i++) begin
        if (rarg[i][ek]) begin
          er[i] <= exp_step(er[i], ek);
        end
      end
    end
    if (cmd.rnd) begin
      ws <= exp_round(es, |squo[SQ_W-1:EXP_STEPS]);
      for (int i = 0; i < CH; i++) begin
        wr[i] <= exp_round(er[i], |rarg[i][RARG_W-1:EXP_STEPS]);
      end
    end
    if (cmd.wmul) begin
      for (int i = 0; i < CH; i++) begin
        wt[i] <= wprod[i][WEIGHT_FRAC_BITS +: W_W];
      end
    end
  end

  // accumulate and divide
  always_ff @(posedge clk) begin
    for (int i = 0; i < CH; i++) begin
      if (cmd.cload) begin
        num[i] <= '0;
        den[i] <= '0;
      end else if (cmd.acc) begin
        num[i] <= num[i] + NUM_W'(W_W'(wt[i]) * (W_W + 8)'(pixel[8*i +: 8]));
        den[i] <= den[i] + DEN_W'(wt[i]);
      end
      if (cmd.finit) begin
        frem[i] <= num[i];
        fq[i]   <= '0;
      end else if (cmd.fdiv) begin
        if (frem[i] >= fdv[i]) begin
          frem[i]   <= frem[i] - fdv[i];
          fq[i][fk] <= 1'b1;
        end
      end
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (cmd.oload) begin
      m_tdata[7:0]   <= (den[0] != '0) ? fq[0] : 8'd0;
      m_tdata[15:8]  <= (color_mode && den[1] != '0) ? fq[1] : 8'd0;
      m_tdata[23:16] <= (color_mode && den[2] != '0) ? fq[2] : 8'd0;
    end
  end

endmodule

// ----- rtl/knnwd_ctrl.sv -----
module knnwd_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic                    s_tuser,
  output logic                    m_tvalid,
  input  logic                    m_tready,
  input  knnwd_pkg::knnwd_stat_t  stat,
  output knnwd_pkg::knnwd_cmd_t   cmd
);
  import knnwd_pkg::*;

  typedef enum logic [14:0] {
    ST_IDLE  = 15'b000000000000001,
    ST_CREAD = 15'b000000000000010,
    ST_CLOAD = 15'b000000000000100,
    ST_NADDR = 15'b000000000001000,
    ST_NLOAD = 15'b000000000010000,
    ST_SQ    = 15'b000000000100000,
    ST_RARG  = 15'b000000001000000,
    ST_SDIV  = 15'b000000010000000,
    ST_EXPO  = 15'b000000100000000,
    ST_RND   = 15'b000001000000000,
    ST_WMUL  = 15'b000010000000000,
    ST_ACC   = 15'b000100000000000,
    ST_FINIT = 15'b001000000000000,
    ST_FDIV  = 15'b010000000000000,
    ST_DONE  = 15'b100000000000000
  } knnwd_state_t;

  knnwd_state_t state;
  knnwd_state_t state_next;
  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  logic out_valid;
  logic out_valid_next;

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = out_valid;

  // sequencer
  always_comb begin
    state_next = state;
    step_next = step;
    out_valid_next = out_valid && !m_tready;
    cmd = '0;
    cmd.step = step;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          if (s_tuser) begin
            cmd.latch = 1'b1;
            state_next = ST_CREAD;
          end else begin
            cmd.store = 1'b1;
          end
        end
      end
      ST_CREAD: begin
        cmd.cread = 1'b1;
        state_next = ST_CLOAD;
      end
      ST_CLOAD: begin
        cmd.cload = 1'b1;
        state_next = stat.rad_zero ? ST_FINIT : ST_NADDR;
      end
      // skip neighbours outside the frame at one a cycle
      ST_NADDR: begin
        if (stat.in_frame) begin
          cmd.nread = 1'b1;
          state_next = ST_NLOAD;
        end else begin
          cmd.adv = 1'b1;
          if (stat.last_pos) begin
            state_next = ST_FINIT;
          end
        end
      end
      ST_NLOAD: begin
        cmd.nload = 1'b1;
        state_next = ST_SQ;
      end
      ST_SQ: begin
        cmd.sq = 1'b1;
        state_next = ST_RARG;
      end
      ST_RARG: begin
        cmd.rarg = 1'b1;
        step_next = SDIV_LAST;
        state_next = ST_SDIV;
      end
      ST_SDIV: begin
        cmd.sdiv = 1'b1;
        if (step == '0) begin
          step_next = '0;
          state_next = ST_EXPO;
        end else begin
          step_next = step - STEP_W'(1);
        end
      end
      ST_EXPO: begin
        cmd.expo = 1'b1;
        if (step == EXP_LAST) begin
          state_next = ST_RND;
        end else begin
          step_next = step + STEP_W'(1);
        end
      end
      ST_RND: begin
        cmd.rnd = 1'b1;
        state_next = ST_WMUL;
      end
      ST_WMUL: begin
        cmd.wmul = 1'b1;
        state_next = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc = 1'b1;
        cmd.adv = 1'b1;
        state_next = stat.last_pos ? ST_FINIT : ST_NADDR;
      end
      ST_FINIT: begin
        cmd.finit = 1'b1;
        step_next = FDIV_LAST;
        state_next = ST_FDIV;
      end
      ST_FDIV: begin
        cmd.fdiv = 1'b1;
        if (step == '0) begin
          state_next = ST_DONE;
        end else begin
          step_next = step - STEP_W'(1);
        end
      end
      // wait for the output register to free up
      ST_DONE: begin
        if (!out_valid || m_tready) begin
          cmd.oload = 1'b1;
          out_valid_next = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      step <= step_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ----- rtl/knn_weighted_denoise.sv -----
// Non-local weighted denoise over a 64x64 frame store of 24-bit pixels. A word with
// tuser 0 writes its pixel into the store and returns nothing; a word with tuser 1
// returns the filtered value of the stored pixel at its row and col, averaged over
// the window [centre-R, centre+R-1] on both axes, neighbours outside the frame
// skipped. Each neighbour inside the frame runs a serial divide for its spatial
// argument and then an exp product chain (spatial and three range weights in
// parallel), then a serial divide per channel ends the item. The block takes one
// item at a time; a result waits in an output register while the next word is
// taken. The frame store holds no reset value: only pixels already written may be
// filtered or fall inside a window.
`include "knn_weighted_denoise_assert.svh"

module knn_weighted_denoise (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [knnwd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [knnwd_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // row, col, chan0_in, chan1_in, chan2_in, zero pad
  input  logic [knnwd_pkg::IN_TDATA_W-1:0]   s_tdata,
  // mode
  input  logic                               s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // chan0_out, chan1_out, chan2_out
  output logic [knnwd_pkg::OUT_TDATA_W-1:0]  m_tdata
);
  import knnwd_pkg::*;

  knnwd_cmd_t  cmd;
  knnwd_stat_t stat;

  knnwd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  knnwd_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .m_tdata   (m_tdata)
  );

  // a filter word makes the block busy, a store word does not
  `KNNWD_ASSERT_NEXT(a_filt_busy, clk, rst, s_tvalid && s_tready && s_tuser, !s_tready)
  `KNNWD_ASSERT_NEXT(a_store_free, clk, rst, s_tvalid && s_tready && !s_tuser, s_tready)
  // store write never collides with a window read
  `KNNWD_ASSERT_NEVER(a_rw_clash, clk, rst, cmd.store && (cmd.cread || cmd.nread))
  // no result straight out of reset
  `KNNWD_ASSERT_AFTER(a_rst_out, clk, rst, !m_tvalid)

endmodule
